// File: sv/apid_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive PID package
// Shared constants, register codes and the command and status types that
// link the controller and the datapath.
// ----------------------------------------------------------------------------
package apid_pkg;

  // Fixed field widths of the configuration registers and the result.
  localparam int GAIN_W    = 24;
  localparam int LIMIT_W   = 15;
  localparam int DRIVE_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Knee of the adaptive gain curve, in error units.
  localparam int ADAPT_KNEE = 100;

  // The adaptive quotient is below kp_span, so it has GAIN_W bits.
  localparam int DIV_STEPS = GAIN_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN     = 3'd0,
    REG_KI_GAIN     = 3'd1,
    REG_KD_GAIN     = 3'd2,
    REG_ITERM_LIMIT = 3'd3,
    REG_OUT_LIMIT   = 3'd4,
    REG_GAIN_MODE   = 3'd5,
    REG_KP_FLOOR    = 3'd6,
    REG_KP_SPAN     = 3'd7
  } cfg_reg_e;

  // Operand pair selected for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SPAN = 2'd0,
    MUL_P    = 2'd1,
    MUL_I    = 2'd2,
    MUL_D    = 2'd3
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;       // capture error and magnitude of a new sample
    logic     clear;      // zero stored error, integral and sum
    logic     mul_en;     // register a product
    mul_sel_e mul_sel;
    logic     kp_fixed;   // take kp from the kp_gain register
    logic     div_init;   // load the divider
    logic     div_step;   // one quotient bit
    logic     kp_adapt;   // take kp from floor plus quotient, saturated
    logic     acc_p;      // sum starts with the P product
    logic     integ_upd;  // integral update and clamp, error history update
    logic     acc_d;      // add the D product
    logic     acc_i;      // add the integral and clamp the sum
    logic     out_load;   // load the result register
  } apid_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic adaptive;
  } apid_sts_t;

endpackage

// File: sv/apid_in_if.sv
// ----------------------------------------------------------------------------
// Adaptive PID input channel
// Valid/ready channel that carries one sample or clear request.
// ----------------------------------------------------------------------------
interface apid_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic signed [SAMPLE_WIDTH-1:0] measured;
  logic signed [SAMPLE_WIDTH-1:0] setpoint;

  modport source (output valid, output kind, output measured, output setpoint, input ready);
  modport sink   (input valid, input kind, input measured, input setpoint, output ready);
endinterface

// File: sv/apid_out_if.sv
// ----------------------------------------------------------------------------
// Adaptive PID output channel
// Valid/ready channel that carries one drive value per request.
// ----------------------------------------------------------------------------
interface apid_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// File: sv/positional_pid_with_adaptive_kp.sv
// ----------------------------------------------------------------------------
// Positional PID with adaptive proportional gain
// Top level: configuration port, channels, controller and datapath.
// ----------------------------------------------------------------------------
// Each request takes one sample at a time through a single shared multiplier.
// A fixed-gain sample steps through gain selection, the three products and
// the accumulation; an adaptive-gain sample also passes through the
// one-bit-per-cycle divider that forms kp_span*|e|/(100+|e|); a clear request
// goes straight to the result. The drive value sits in an output register,
// so the next request is taken while the previous result still waits on the
// output side. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; the user must write it only while no request is in progress,
// which the block itself does not enforce. Gains are Q8.16 and limits are in
// integer units.
// ----------------------------------------------------------------------------
module positional_pid_with_adaptive_kp #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [apid_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [apid_pkg::GAIN_W-1:0]    cfg_wdata_i,
  apid_in_if.sink                        in_if,
  apid_out_if.source                     out_if
);
  import apid_pkg::*;

  apid_cmd_t cmd;
  apid_sts_t sts;

  // Sequencer and handshakes.
  apid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_kind_i   (in_if.kind),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and stored state.
  apid_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .measured_i  (in_if.measured),
    .setpoint_i  (in_if.setpoint),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .drive_o     (out_if.drive)
  );

endmodule

// File: sv/apid_dp.sv
// ----------------------------------------------------------------------------
// Adaptive PID datapath
// Configuration registers, error capture, shared multiplier, radix-2 divider
// for the adaptive gain, integral and sum accumulation with clamps, and the
// result register.
// ----------------------------------------------------------------------------
module apid_dp #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [apid_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [apid_pkg::GAIN_W-1:0]           cfg_wdata_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        measured_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        setpoint_i,
  input  apid_pkg::apid_cmd_t                   cmd_i,
  output apid_pkg::apid_sts_t                   sts_o,
  output logic signed [apid_pkg::DRIVE_W-1:0]   drive_o
);
  import apid_pkg::*;

  localparam int ERR_W  = SAMPLE_WIDTH + 1;
  localparam int MAG_W  = SAMPLE_WIDTH + 1;
  localparam int OPD_W  = SAMPLE_WIDTH + 2;
  localparam int PROD_W = GAIN_W + 1 + OPD_W;
  localparam int NUM_W  = GAIN_W + MAG_W;
  localparam int DVS_W  = SAMPLE_WIDTH + 2;
  localparam int LIM_W  = LIMIT_W + GAIN_FRAC_BITS + 1;
  localparam int ACC_W  = (PROD_W > LIM_W) ? PROD_W + 2 : LIM_W + 2;

  // Configuration registers.
  logic [GAIN_W-1:0]  kp_gain_q, ki_gain_q, kd_gain_q, kp_floor_q, kp_span_q;
  logic [LIMIT_W-1:0] iterm_limit_q, out_limit_q;
  logic               gain_mode_q;

  // Working registers.
  logic signed [ERR_W-1:0]   e_q, e_d;
  logic [MAG_W-1:0]          mag_q, mag_d;
  logic signed [ERR_W-1:0]   last_err_q;
  logic signed [LIM_W-1:0]   integ_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [GAIN_W-1:0]         kp_q;
  logic [DVS_W-1:0]          rem_q, rem_d, dvs_q;
  logic [GAIN_W-1:0]         qsh_q;
  logic                      q_bit;
  logic signed [DRIVE_W-1:0] drive_q;

  logic [GAIN_W-1:0]         mul_a;
  logic signed [OPD_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [DVS_W:0]            div_t, div_sub;
  logic [GAIN_W:0]           ksum;
  logic signed [ACC_W-1:0]   ilim, olim, isum, iclamp, osum, oclamp;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_gain_q     <= '0;
      ki_gain_q     <= '0;
      kd_gain_q     <= '0;
      iterm_limit_q <= '0;
      out_limit_q   <= '0;
      gain_mode_q   <= 1'b0;
      kp_floor_q    <= '0;
      kp_span_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KP_GAIN:     kp_gain_q     <= cfg_wdata_i;
        REG_KI_GAIN:     ki_gain_q     <= cfg_wdata_i;
        REG_KD_GAIN:     kd_gain_q     <= cfg_wdata_i;
        REG_ITERM_LIMIT: iterm_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        REG_OUT_LIMIT:   out_limit_q   <= cfg_wdata_i[LIMIT_W-1:0];
        REG_GAIN_MODE:   gain_mode_q   <= cfg_wdata_i[0];
        REG_KP_FLOOR:    kp_floor_q    <= cfg_wdata_i;
        REG_KP_SPAN:     kp_span_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign sts_o.adaptive = gain_mode_q;

  // Error and its magnitude of an incoming sample.
  always_comb begin
    e_d   = $signed({setpoint_i[SAMPLE_WIDTH-1], setpoint_i})
          - $signed({measured_i[SAMPLE_WIDTH-1], measured_i});
    mag_d = e_d[ERR_W-1] ? MAG_W'(-e_d) : MAG_W'(e_d);
  end

  // Shared multiplier: unsigned gain times a signed operand.
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_SPAN: begin
        mul_a = kp_span_q;
        mul_b = $signed({1'b0, mag_q});
      end
      MUL_P: begin
        mul_a = kp_q;
        mul_b = OPD_W'(e_q);
      end
      MUL_I: begin
        mul_a = ki_gain_q;
        mul_b = OPD_W'(e_q);
      end
      MUL_D: begin
        mul_a = kd_gain_q;
        mul_b = OPD_W'(e_q) - OPD_W'(last_err_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = $signed({1'b0, mul_a}) * mul_b;
  end

  // One restoring division step; the remainder stays below the divisor.
  always_comb begin
    div_t   = {rem_q, qsh_q[GAIN_W-1]};
    div_sub = div_t - {1'b0, dvs_q};
    q_bit   = (div_t >= {1'b0, dvs_q});
    rem_d   = q_bit ? div_sub[DVS_W-1:0] : div_t[DVS_W-1:0];
  end

  // Adaptive gain: floor plus quotient, saturated at the gain maximum.
  assign ksum = {1'b0, kp_floor_q} + {1'b0, qsh_q};

  // Integral update with its symmetric clamp.
  always_comb begin
    ilim = $signed(ACC_W'({iterm_limit_q, {GAIN_FRAC_BITS{1'b0}}}));
    isum = ACC_W'(integ_q) + ACC_W'(prod_q);
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
  end

  // Final sum with the output clamp.
  always_comb begin
    olim = $signed(ACC_W'({out_limit_q, {GAIN_FRAC_BITS{1'b0}}}));
    osum = acc_q + ACC_W'(integ_q);
    if (osum > olim) begin
      oclamp = olim;
    end else if (osum < -olim) begin
      oclamp = -olim;
    end else begin
      oclamp = osum;
    end
  end

  // Controller state that survives between samples.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= '0;
      acc_q      <= '0;
    end else begin
      if (cmd_i.clear) begin
        last_err_q <= '0;
        integ_q    <= '0;
        acc_q      <= '0;
      end else begin
        if (cmd_i.integ_upd) begin
          integ_q    <= LIM_W'(iclamp);
          last_err_q <= e_q;
        end
        if (cmd_i.acc_p) begin
          acc_q <= ACC_W'(prod_q);
        end else if (cmd_i.acc_d) begin
          acc_q <= acc_q + ACC_W'(prod_q);
        end else if (cmd_i.acc_i) begin
          acc_q <= oclamp;
        end
      end
    end
  end

  // Per-sample working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      e_q   <= e_d;
      mag_q <= mag_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.div_init) begin
      rem_q <= DVS_W'(prod_q[NUM_W-1:GAIN_W]);
      qsh_q <= prod_q[GAIN_W-1:0];
      dvs_q <= DVS_W'(mag_q) + DVS_W'(ADAPT_KNEE);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      qsh_q <= {qsh_q[GAIN_W-2:0], q_bit};
    end
    if (cmd_i.kp_fixed) begin
      kp_q <= kp_gain_q;
    end else if (cmd_i.kp_adapt) begin
      kp_q <= ksum[GAIN_W] ? {GAIN_W{1'b1}} : ksum[GAIN_W-1:0];
    end
    if (cmd_i.out_load) begin
      drive_q <= DRIVE_W'(acc_q >>> GAIN_FRAC_BITS);
    end
  end

  assign drive_o = drive_q;

  // A clear request leaves all stored terms at zero.
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (integ_q == '0 && last_err_q == '0 && acc_q == '0))
    else $error("clear did not zero the stored terms");

  // The integral stays inside its limit after each update.
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.integ_upd |=>
      (integ_q <= $signed({1'b0, $past(iterm_limit_q), {GAIN_FRAC_BITS{1'b0}}}) &&
       integ_q >= -$signed({1'b0, $past(iterm_limit_q), {GAIN_FRAC_BITS{1'b0}}})))
    else $error("integral outside its limit");

  // A loaded drive value lies inside the output limit.
  a_drive_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=>
      (drive_q <= $signed({1'b0, $past(out_limit_q)}) &&
       drive_q >= -$signed({1'b0, $past(out_limit_q)})))
    else $error("drive outside the output limit");

endmodule

// File: sv/apid_ctrl.sv
// ----------------------------------------------------------------------------
// Adaptive PID controller
// Sequencer that steps the datapath through gain selection, division in
// adaptive mode, the three products and the accumulation, and owns both handshakes.
// ----------------------------------------------------------------------------
module apid_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  apid_pkg::apid_sts_t  sts_i,
  output apid_pkg::apid_cmd_t  cmd_o
);
  import apid_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_KSEL,
    S_DIV_LD,
    S_DIV,
    S_KP_AD,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ADD_D,
    S_ADD_I,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             accept;
  logic             out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Sequencer state, division count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result takes priority over the one being taken in this cycle.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= in_kind_i ? S_DONE : S_KSEL;
          end
        end
        S_KSEL: state_q <= sts_i.adaptive ? S_DIV_LD : S_MUL_P;
        S_DIV_LD: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= S_KP_AD;
          end
        end
        S_KP_AD: state_q <= S_MUL_P;
        S_MUL_P: state_q <= S_MUL_I;
        S_MUL_I: state_q <= S_MUL_D;
        S_MUL_D: state_q <= S_ADD_D;
        S_ADD_D: state_q <= S_ADD_I;
        S_ADD_I: state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load  = accept && !in_kind_i;
        cmd_o.clear = accept && in_kind_i;
      end
      S_KSEL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_SPAN;
        cmd_o.kp_fixed = !sts_i.adaptive;
      end
      S_DIV_LD: cmd_o.div_init = 1'b1;
      S_DIV:    cmd_o.div_step = 1'b1;
      S_KP_AD:  cmd_o.kp_adapt = 1'b1;
      S_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P;
      end
      S_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_I;
        cmd_o.acc_p   = 1'b1;
      end
      S_MUL_D: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_D;
        cmd_o.integ_upd = 1'b1;
      end
      S_ADD_D: cmd_o.acc_d    = 1'b1;
      S_ADD_I: cmd_o.acc_i    = 1'b1;
      S_DONE:  cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  // The divider always runs for the full number of quotient bits.
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_LD) |-> ##(DIV_STEPS + 1) (state_q == S_KP_AD))
    else $error("divider step count wrong");

  // A pending result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.out_load)
    else $error("result overwritten before it was taken");

  // After a request is taken the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("new request taken while one is in progress");

endmodule

// File: bench/tb_positional_pid_with_adaptive_kp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive PID controller testbench
// Drives sample and clear requests through the input channel, predicts each
// drive value with a local fixed-point PID model, and checks every result in
// order. Gains and limits are reprogrammed between phases while the block is
// idle. Both channel sides idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_positional_pid_with_adaptive_kp;
  import apid_pkg::*;

  localparam int     SAMPLE_W        = 16;
  localparam int     FRAC            = 16;
  localparam longint GAIN_MAX_VAL    = (longint'(1) << GAIN_W) - 1;
  localparam logic   KIND_UPDATE     = 1'b0;
  localparam logic   KIND_CLEAR      = 1'b1;
  localparam int     RAND_PHASES     = 8;
  localparam int     RAND_PER_PHASE  = 105;
  localparam int     LONG_HOLD       = 300;
  localparam int     DRAIN_CYCLES    = 40;
  localparam int     WATCHDOG_LIMIT  = 3000;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] measured;
    logic signed [SAMPLE_W-1:0] setpoint;
  } pid_sample_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [GAIN_W-1:0]    cfg_wdata;

  apid_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
  apid_out_if out_ch ();

  positional_pid_with_adaptive_kp dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // Register copies as the block holds them.
  logic [GAIN_W-1:0]  gain_kp, gain_ki, gain_kd, adapt_floor, adapt_span;
  logic [LIMIT_W-1:0] lim_iterm, lim_out;
  logic               adapt_on;

  // Controller state: previous error and integral with FRAC fraction bits.
  longint err_prev;
  longint integ_fx;

  pid_sample_t sample_q[$];
  logic signed [DRIVE_W-1:0] drive_q[$];

  pid_sample_t cur;
  bit          req_taken;
  bit          idle_en;
  int          src_gap;
  int          sink_gap;
  int          sink_hold;
  int          sink_block_req;
  int          sink_block_seen;
  int          stall_cycles;
  int          fail_cnt;

  always #5 clk = ~clk;

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Computes the drive value of one request and advances the controller state.
  function automatic logic signed [DRIVE_W-1:0] calc_drive(pid_sample_t s);
    longint err, kp_eff, sum;
    longint unsigned mag, quot;
    if (s.kind == KIND_CLEAR) begin
      err_prev = 0;
      integ_fx = 0;
      return '0;
    end
    err = longint'(s.setpoint) - longint'(s.measured);
    mag = (err < 0) ? -err : err;
    if (adapt_on) begin
      quot   = (64'(adapt_span) * mag) / (64'(ADAPT_KNEE) + mag);
      kp_eff = longint'(adapt_floor) + longint'(quot);
      if (kp_eff > GAIN_MAX_VAL) kp_eff = GAIN_MAX_VAL;
    end else begin
      kp_eff = longint'(gain_kp);
    end
    integ_fx = clamp_sym(integ_fx + longint'(gain_ki) * err, longint'(lim_iterm) << FRAC);
    sum = kp_eff * err + integ_fx + longint'(gain_kd) * (err - err_prev);
    err_prev = err;
    sum = clamp_sym(sum, longint'(lim_out) << FRAC);
    // Arithmetic shift rounds toward minus infinity.
    sum = sum >>> FRAC;
    return sum[DRIVE_W-1:0];
  endfunction

  // Register write; the local copy keeps only the register's own width.
  task automatic write_reg(cfg_reg_e idx, logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_KP_GAIN:     gain_kp = val;
      REG_KI_GAIN:     gain_ki = val;
      REG_KD_GAIN:     gain_kd = val;
      REG_ITERM_LIMIT: lim_iterm = val[LIMIT_W-1:0];
      REG_OUT_LIMIT:   lim_out = val[LIMIT_W-1:0];
      REG_GAIN_MODE:   adapt_on = val[0];
      REG_KP_FLOOR:    adapt_floor = val;
      REG_KP_SPAN:     adapt_span = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                              logic [GAIN_W-1:0] kd, logic [GAIN_W-1:0] ilim,
                              logic [GAIN_W-1:0] olim, logic [GAIN_W-1:0] mode,
                              logic [GAIN_W-1:0] kfloor, logic [GAIN_W-1:0] kspan);
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_KD_GAIN, kd);
    write_reg(REG_ITERM_LIMIT, ilim);
    write_reg(REG_OUT_LIMIT, olim);
    write_reg(REG_GAIN_MODE, mode);
    write_reg(REG_KP_FLOOR, kfloor);
    write_reg(REG_KP_SPAN, kspan);
  endtask

  task automatic push_update(logic signed [SAMPLE_W-1:0] meas,
                             logic signed [SAMPLE_W-1:0] setp);
    pid_sample_t s;
    s.kind     = KIND_UPDATE;
    s.measured = meas;
    s.setpoint = setp;
    sample_q.push_back(s);
  endtask

  // Clear requests carry random sample fields, which the block ignores.
  task automatic push_clear();
    pid_sample_t s;
    s.kind     = KIND_CLEAR;
    s.measured = SAMPLE_W'($urandom);
    s.setpoint = SAMPLE_W'($urandom);
    sample_q.push_back(s);
  endtask

  // Mostly tracking samples close to the setpoint, plus extremes, noise and clears.
  task automatic push_random_sample();
    int sp;
    int ms;
    case ($urandom_range(0, 15))
      0: push_clear();
      1: push_update($urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF,
                     $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF);
      2, 3, 4, 5, 6: push_update(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      default: begin
        sp = int'($urandom_range(0, 4000)) - 2000;
        ms = sp + int'($urandom_range(0, 400)) - 200;
        push_update(ms[SAMPLE_W-1:0], sp[SAMPLE_W-1:0]);
      end
    endcase
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      4:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 24'h3FFFF));
    endcase
  endfunction

  // Limits sometimes carry upper bits that the register must drop.
  function automatic logic [GAIN_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return GAIN_W'(15'h7FFF);
      2:       return GAIN_W'($urandom_range(0, 32767));
      3:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 2000));
    endcase
  endfunction

  // Waits until every request is taken and every drive value has come back.
  task automatic drain();
    while (sample_q.size() != 0 || in_ch.valid || drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Acceptance of an input request: predict its drive value.
  always @(posedge clk) begin
    req_taken = rst_n && in_ch.valid && in_ch.ready;
    if (req_taken) begin
      drive_q.push_back(calc_drive('{kind: in_ch.kind, measured: in_ch.measured,
                                     setpoint: in_ch.setpoint}));
    end
  end

  // Request driver: holds a request until taken, then maybe a gap.
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || req_taken)) begin
      if (req_taken && idle_en && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 15);
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        cur = sample_q.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= cur.kind;
        in_ch.measured <= cur.measured;
        in_ch.setpoint <= cur.setpoint;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side ready: one long hold-off on request, otherwise random bursts.
  always @(negedge clk) begin
    if (rst_n) begin
      if (sink_block_req != sink_block_seen) begin
        sink_block_seen = sink_block_req;
        sink_hold = LONG_HOLD;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 15);
      end
    end
  end

  // Result check against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_q.size() == 0) begin
        $error("drive: no request outstanding, got %0d", out_ch.drive);
        fail_cnt++;
      end else if (out_ch.drive !== drive_q[0]) begin
        $error("drive: expected %0d, got %0d", drive_q[0], out_ch.drive);
        fail_cnt++;
        void'(drive_q.pop_front());
      end else begin
        void'(drive_q.pop_front());
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("positional_pid_with_adaptive_kp: mismatch");
        $finish;
      end
    end else begin
      stall_cycles = 0;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_KP_GAIN;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = KIND_UPDATE;
    in_ch.measured = '0;
    in_ch.setpoint = '0;
    out_ch.ready   = 1'b0;
    gain_kp = '0; gain_ki = '0; gain_kd = '0;
    adapt_floor = '0; adapt_span = '0;
    lim_iterm = '0; lim_out = '0; adapt_on = 1'b0;
    err_prev = 0; integ_fx = 0;
    idle_en = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fixed gain of one: field extremes, small errors of both signs, a clear.
    program_regs(24'h010000, 24'h004000, 24'h008000, 24'd1000, 24'd32767, 24'd0,
                 24'h020000, 24'h100000);
    push_update(16'sd0, 16'sd0);
    push_update(-16'sd32768, 16'sd32767);
    push_update(16'sd32767, -16'sd32768);
    push_update(16'sd0, 16'sd1);
    push_update(16'sd1, 16'sd0);
    push_clear();
    push_update(16'sd5, 16'sd3);
    push_update(-16'sd100, 16'sd100);
    drain();

    // Zero limits force the integral and the output to zero.
    program_regs(24'h008001, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    push_update(16'sd100, -16'sd100);
    push_update(-16'sd7, 16'sd7);
    push_clear();
    drain();

    // Widest limits; a negative error with a fractional gain rounds down.
    program_regs(24'h008001, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFF, 24'h7FFF, 24'd0, 24'd0, 24'd0);
    push_update(16'sd32767, -16'sd32768);
    push_update(-16'sd32768, 16'sd32767);
    push_update(16'sd3, 16'sd0);
    drain();

    // Adaptive gain saturating at the gain maximum, then a pure span curve.
    program_regs(24'd0, 24'd0, 24'd0, 24'h7FFF, 24'h7FFF, 24'd1, 24'hFFFFFF, 24'hFFFFFF);
    push_update(16'sd0, 16'sd0);
    push_update(-16'sd32768, 16'sd32767);
    push_update(16'sd10, 16'sd0);
    drain();
    program_regs(24'd0, 24'h000100, 24'h000800, 24'd500, 24'h7FFF, 24'd1, 24'd0, 24'hFFFFFF);
    push_update(16'sd0, 16'sd50);
    push_update(16'sd0, -16'sd50);
    drain();

    // Random phases with fresh settings; the last one runs without idling.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) idle_en = 1'b0;
      program_regs(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
                   GAIN_W'($urandom), pick_gain(), pick_gain());
      if (ph == 0) sink_block_req++;
      repeat (RAND_PER_PHASE) push_random_sample();
      drain();
    end

    if (drive_q.size() != 0) begin
      $error("drive: %0d results never arrived", drive_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("positional_pid_with_adaptive_kp: match");
    end else begin
      $display("positional_pid_with_adaptive_kp: mismatch");
    end
    $finish;
  end

endmodule
